/* rtl/core/tga_rle_image_decoder_macros.svh */
// Assertion macros shared by the decoder RTL files.
`ifndef TGA_RLE_IMAGE_DECODER_MACROS_SVH
`define TGA_RLE_IMAGE_DECODER_MACROS_SVH
`ifndef SYNTH
// Clocked check, switched off while reset is high.
`define TGA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds through reset.
`define TGA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TGA_ASSERT(label, clk, rst, prop, msg)
`define TGA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/core/tga_rle_pkg.sv */
// Types and constants shared by the TGA decoder modules.
package tga_rle_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned HEADER_BYTES = 18;
  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;
  localparam logic [4:0] HDR_ID_LEN = 5'd0;
  localparam logic [4:0] HDR_TYPE = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH = 5'd16;
  localparam logic [4:0] HDR_LAST = 5'(HEADER_BYTES - 1);
  localparam logic [4:0] DEPTH_3 = 5'd3;
  localparam logic [4:0] DEPTH_4 = 5'd4;
  localparam logic [7:0] RUN_FLAG = 8'd128;
  localparam logic [7:0] OPAQUE = 8'd255;

  typedef enum logic [1:0] {
    KIND_INFO  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Decoded event handed from the parser to the output stage
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic [7:0]  rep;
    logic        last;
    logic [15:0] width;
    logic [15:0] height;
    logic        four;
  } token_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

/* rtl/core/tga_rle_ifs.sv */
// Valid/ready channel interfaces for file bytes and decoded items.
interface tga_rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_file;

  modport source (output valid, output file_byte, output start_file, input ready);
  modport sink (input valid, input file_byte, input start_file, output ready);
endinterface

interface tga_rle_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  repeat_count;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  bytes_per_pixel;
  logic        last_pixel;

  modport source (
    output valid, output kind, output red, output green, output blue, output alpha,
    output repeat_count, output image_width, output image_height,
    output bytes_per_pixel, output last_pixel, input ready
  );
  modport sink (
    input valid, input kind, input red, input green, input blue, input alpha,
    input repeat_count, input image_width, input image_height,
    input bytes_per_pixel, input last_pixel, output ready
  );
endinterface

/* rtl/core/tga_rle_image_decoder.sv */
// Top level of the TGA true-colour RLE decoder.
// Takes a TGA file one byte per cycle while file_bytes.ready is high and gives
// an info item after the header, an error item for an unsupported type or
// depth, then one pixel item per raw pixel or run, colours as red, green, blue,
// alpha with a repeat count and the last one marked. The parser state updates
// on each accepted byte, so a byte can be accepted each clock while ready is
// high and at most one item results from it. A queue of QUEUE_DEPTH tokens
// sits between the parser and the output register; file_bytes.ready falls only
// when that queue is full, which happens once the output register holds an
// item that is not taken and QUEUE_DEPTH more items wait behind it. An item is
// written into the queue, then loaded into the output register.
module tga_rle_image_decoder #(
  parameter int unsigned QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
  input logic           clk,
  input logic           rst,
  tga_rle_in_if.sink    file_bytes,
  tga_rle_out_if.source items
);

  logic                   push;
  tga_rle_pkg::token_t    push_token;
  logic                   pop;
  tga_rle_pkg::token_t    head;
  tga_rle_pkg::q_status_t q_status;

  tga_rle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .file_bytes (file_bytes),
    .q_status   (q_status),
    .push       (push),
    .push_token (push_token)
  );

  tga_rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  tga_rle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .items    (items)
  );

endmodule

/* rtl/core/tga_rle_front.sv */
// Byte parser: header, ID skip, packet headers and colour bytes into tokens.
`include "tga_rle_image_decoder_macros.svh"

module tga_rle_front (
  input  logic                  clk,
  input  logic                  rst,
  tga_rle_in_if.sink            file_bytes,
  input  tga_rle_pkg::q_status_t q_status,
  output logic                  push,
  output tga_rle_pkg::token_t   push_token
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_PKTHDR,
    PH_COLOR,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  header_index, header_index_next;
  logic [7:0]  id_skip_left, id_skip_left_next;
  logic        is_compressed, is_compressed_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic        four_bytes, four_bytes_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  color_byte_index, color_byte_index_next;
  logic [7:0]  color_hold [3];
  logic [7:0]  color_hold_next [3];

  logic                in_fire;
  logic                emit;
  tga_rle_pkg::token_t token;

  assign file_bytes.ready = !q_status.full;
  assign in_fire = file_bytes.valid && file_bytes.ready;
  assign push = in_fire && emit;
  assign push_token = token;

  // Work out the next parser state for the byte on the channel
  always_comb begin
    logic [7:0]  b;
    phase_t      ph;
    logic [4:0]  hi;
    logic [7:0]  cnt;
    logic [7:0]  rep;
    logic [1:0]  lastk;
    logic [31:0] pl_after;
    logic [7:0]  pk_after;
    b = file_bytes.file_byte;
    ph = phase;
    hi = header_index;
    cnt = '0;
    rep = '0;
    lastk = '0;
    pl_after = '0;
    pk_after = '0;

    phase_next = phase;
    header_index_next = header_index;
    id_skip_left_next = id_skip_left;
    is_compressed_next = is_compressed;
    width_reg_next = width_reg;
    height_reg_next = height_reg;
    four_bytes_next = four_bytes;
    pixels_left_next = pixels_left;
    packet_is_run_next = packet_is_run;
    packet_left_next = packet_left;
    color_byte_index_next = color_byte_index;
    color_hold_next = color_hold;

    // Restart marker: take the byte as header byte zero of a fresh file
    if (file_bytes.start_file) begin
      ph = PH_HEADER;
      hi = '0;
      phase_next = PH_HEADER;
      header_index_next = '0;
      id_skip_left_next = '0;
      is_compressed_next = 1'b0;
      width_reg_next = '0;
      height_reg_next = '0;
      four_bytes_next = 1'b0;
      pixels_left_next = '0;
      packet_is_run_next = 1'b0;
      packet_left_next = '0;
      color_byte_index_next = '0;
    end

    emit = 1'b0;
    token = '0;

    case (ph)
      PH_HEADER: begin
        header_index_next = hi + 5'd1;
        case (hi)
          tga_rle_pkg::HDR_ID_LEN: id_skip_left_next = b;
          tga_rle_pkg::HDR_TYPE: begin
            if (b == tga_rle_pkg::TYPE_RAW) begin
              is_compressed_next = 1'b0;
            end else if (b == tga_rle_pkg::TYPE_RLE) begin
              is_compressed_next = 1'b1;
            end else begin
              phase_next = PH_ERROR;
              header_index_next = hi;
              emit = 1'b1;
              token.kind = tga_rle_pkg::KIND_ERROR;
            end
          end
          tga_rle_pkg::HDR_WIDTH_LO: width_reg_next[7:0] = b;
          tga_rle_pkg::HDR_WIDTH_HI: width_reg_next[15:8] = b;
          tga_rle_pkg::HDR_HEIGHT_LO: height_reg_next[7:0] = b;
          tga_rle_pkg::HDR_HEIGHT_HI: height_reg_next[15:8] = b;
          tga_rle_pkg::HDR_DEPTH: begin
            if (b[7:3] == tga_rle_pkg::DEPTH_3) begin
              four_bytes_next = 1'b0;
            end else if (b[7:3] == tga_rle_pkg::DEPTH_4) begin
              four_bytes_next = 1'b1;
            end else begin
              phase_next = PH_ERROR;
              header_index_next = hi;
              emit = 1'b1;
              token.kind = tga_rle_pkg::KIND_ERROR;
            end
          end
          default: begin
            if (hi >= tga_rle_pkg::HDR_LAST) begin
              header_index_next = hi;
              pixels_left_next = {16'b0, width_reg} * {16'b0, height_reg};
              emit = 1'b1;
              token.kind = tga_rle_pkg::KIND_INFO;
              token.width = width_reg;
              token.height = height_reg;
              token.four = four_bytes;
              color_byte_index_next = '0;
              if (id_skip_left != '0) begin
                phase_next = PH_IDSKIP;
              end else if (width_reg == '0 || height_reg == '0) begin
                phase_next = PH_DONE;
              end else if (is_compressed) begin
                phase_next = PH_PKTHDR;
              end else begin
                packet_is_run_next = 1'b0;
                packet_left_next = 8'd1;
                phase_next = PH_COLOR;
              end
            end
          end
        endcase
      end
      PH_IDSKIP: begin
        if (id_skip_left != '0) begin
          id_skip_left_next = id_skip_left - 8'd1;
        end
        if (id_skip_left <= 8'd1) begin
          color_byte_index_next = '0;
          if (pixels_left == '0) begin
            phase_next = PH_DONE;
          end else if (is_compressed) begin
            phase_next = PH_PKTHDR;
          end else begin
            packet_is_run_next = 1'b0;
            packet_left_next = 8'd1;
            phase_next = PH_COLOR;
          end
        end
      end
      PH_PKTHDR: begin
        // Packet header: low seven bits plus one pixels, top bit marks a run
        cnt = {1'b0, b[6:0]} + 8'd1;
        packet_is_run_next = b[7];
        if ({24'b0, cnt} > pixels_left) begin
          cnt = pixels_left[7:0];
        end
        packet_left_next = cnt;
        color_byte_index_next = '0;
        phase_next = PH_COLOR;
      end
      PH_COLOR: begin
        lastk = four_bytes ? 2'd3 : 2'd2;
        if (color_byte_index < lastk) begin
          if (color_byte_index != 2'd3) begin
            color_hold_next[color_byte_index] = b;
          end
          color_byte_index_next = color_byte_index + 2'd1;
        end else begin
          if (!four_bytes) begin
            color_hold_next[2] = b;
          end
          color_byte_index_next = '0;
          rep = packet_is_run ? packet_left : 8'd1;
          if ({24'b0, rep} > pixels_left) begin
            rep = pixels_left[7:0];
          end
          if (rep > packet_left) begin
            rep = packet_left;
          end
          pl_after = pixels_left - {24'b0, rep};
          pk_after = packet_left - rep;
          pixels_left_next = pl_after;
          packet_left_next = pk_after;
          emit = 1'b1;
          token.kind = tga_rle_pkg::KIND_PIXEL;
          token.c0 = color_hold[0];
          token.c1 = color_hold[1];
          token.c2 = four_bytes ? color_hold[2] : b;
          token.c3 = b;
          token.rep = rep;
          token.four = four_bytes;
          if (pl_after == '0) begin
            token.last = 1'b1;
            phase_next = PH_DONE;
          end else if (pk_after == '0) begin
            if (is_compressed) begin
              phase_next = PH_PKTHDR;
            end else begin
              packet_left_next = 8'd1;
              packet_is_run_next = 1'b0;
            end
          end
        end
      end
      default: begin
        // Done or error: drop the byte
      end
    endcase
  end

  // Hold parser state; advance on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      header_index <= '0;
      id_skip_left <= '0;
      is_compressed <= 1'b0;
      width_reg <= '0;
      height_reg <= '0;
      four_bytes <= 1'b0;
      pixels_left <= '0;
      packet_is_run <= 1'b0;
      packet_left <= '0;
      color_byte_index <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      header_index <= header_index_next;
      id_skip_left <= id_skip_left_next;
      is_compressed <= is_compressed_next;
      width_reg <= width_reg_next;
      height_reg <= height_reg_next;
      four_bytes <= four_bytes_next;
      pixels_left <= pixels_left_next;
      packet_is_run <= packet_is_run_next;
      packet_left <= packet_left_next;
      color_byte_index <= color_byte_index_next;
    end
  end

  // Colour bytes need no reset: each is written before it is read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      color_hold <= color_hold_next;
    end
  end

  `TGA_ASSERT(a_quiet_after_error, clk, rst, (phase == PH_ERROR && in_fire && !file_bytes.start_file) |-> !push, "item produced after a format error")
  `TGA_ASSERT(a_packet_within_image, clk, rst, (phase == PH_COLOR) |-> ({24'b0, packet_left} <= pixels_left), "packet runs past the image end")

endmodule

/* rtl/core/tga_rle_queue.sv */
// Short token queue between the parser and the output stage.
`include "tga_rle_image_decoder_macros.svh"

module tga_rle_queue #(
  parameter int unsigned DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tga_rle_pkg::token_t    push_token,
  input  logic                   pop,
  output tga_rle_pkg::token_t    head,
  output tga_rle_pkg::q_status_t status
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tga_rle_pkg::token_t slots [DEPTH];
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W-1:0]    wr_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign status.full = (count == CNT_W'(DEPTH));
  assign status.valid = (count != '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && status.valid;
  assign head = slots[rd_ptr];

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed token
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  `TGA_ASSERT(a_no_push_when_full, clk, rst, push |-> !status.full, "token pushed into a full queue")
  `TGA_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count above depth")

endmodule

/* rtl/core/tga_rle_back.sv */
// Output stage: formats queued tokens into result items and holds them.
`include "tga_rle_image_decoder_macros.svh"

module tga_rle_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tga_rle_pkg::token_t    head,
  input  tga_rle_pkg::q_status_t q_status,
  output logic                   pop,
  tga_rle_out_if.source          items
);

  logic load;
  logic is_info;
  logic is_pixel;

  assign load = q_status.valid && (!items.valid || items.ready);
  assign pop = load;
  assign is_info = (head.kind == tga_rle_pkg::KIND_INFO);
  assign is_pixel = (head.kind == tga_rle_pkg::KIND_PIXEL);

  // Hold the valid flag until the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      items.valid <= 1'b0;
    end else if (load) begin
      items.valid <= 1'b1;
    end else if (items.ready) begin
      items.valid <= 1'b0;
    end
  end

  // Swap colour order, fill alpha and clear fields that mean nothing
  always_ff @(posedge clk) begin
    if (load) begin
      items.kind <= head.kind;
      items.red <= is_pixel ? head.c2 : 8'd0;
      items.green <= is_pixel ? head.c1 : 8'd0;
      items.blue <= is_pixel ? head.c0 : 8'd0;
      items.alpha <= is_pixel ? (head.four ? head.c3 : tga_rle_pkg::OPAQUE) : 8'd0;
      items.repeat_count <= is_pixel ? head.rep : 8'd0;
      items.last_pixel <= is_pixel ? head.last : 1'b0;
      items.image_width <= is_info ? head.width : 16'd0;
      items.image_height <= is_info ? head.height : 16'd0;
      items.bytes_per_pixel <= is_info ? (head.four ? 3'd4 : 3'd3) : 3'd0;
    end
  end

  `TGA_ASSERT(a_load_shows_item, clk, rst, load |=> items.valid, "loaded item not presented")

endmodule
